// ----- design/psc_pkg.sv -----
package psc_pkg;

  // coordinate width used when the top level is not overridden
  localparam int COORD_BITS_DEF = 32;

  // Q16.16 fraction bits, the unit one is 1 << FRAC_BITS
  localparam int FRAC_BITS = 16;

  // tolerance register
  localparam int                   TOL_BITS  = 15;
  localparam logic [TOL_BITS-1:0]  TOL_RESET = 15'd7;

  // configuration port
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;
  localparam int REG_IDX_W = ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_TOLERANCE = '0;

  // limb multiplier: digit size and register stages
  localparam int MUL_LIMB   = 32;
  localparam int MUL_STAGES = 3;

  // action codes
  localparam logic ACT_PLANAR  = 1'b0;
  localparam logic ACT_SPATIAL = 1'b1;

  localparam int REL_W = 4;

  typedef enum logic [REL_W-1:0] {
    REL_UNKNOWN  = 4'd0,
    REL_DISJOINT = 4'd1,
    REL_LEFT     = 4'd2,
    REL_RIGHT    = 4'd3,
    REL_BEFORE   = 4'd4,
    REL_AFTER    = 4'd5,
    REL_BETWEEN  = 4'd6,
    REL_AT_START = 4'd7,
    REL_AT_END   = 4'd8
  } rel_t;

endpackage

// ----- design/psc_mul.sv -----
module psc_mul
  import psc_pkg::*;
#(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);

  localparam int NA  = AW / MUL_LIMB + 1;
  localparam int NB  = BW / MUL_LIMB + 1;
  localparam int AXW = NA * MUL_LIMB;
  localparam int BXW = NB * MUL_LIMB;
  localparam int DGW = MUL_LIMB + 1;
  localparam int PPW = 2 * DGW;
  localparam int PW  = AW + BW;

  logic [AXW-1:0] a_x;
  logic [BXW-1:0] b_x;

  logic signed [DGW-1:0] a_dig [NA];
  logic signed [DGW-1:0] b_dig [NB];

  logic signed [PPW-1:0] pp [NA][NB];

  logic [PW-1:0] row_sum [NA];
  logic [PW-1:0] row_q   [NA];
  logic [PW-1:0] total;

  assign a_x = {{(AXW-AW){a[AW-1]}}, a};
  assign b_x = {{(BXW-BW){b[BW-1]}}, b};

  // lower digits unsigned, top digit carries the sign
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      if (i == NA - 1) begin
        a_dig[i] = {a_x[AXW-1], a_x[i*MUL_LIMB +: MUL_LIMB]};
      end else begin
        a_dig[i] = {1'b0, a_x[i*MUL_LIMB +: MUL_LIMB]};
      end
    end
    for (int j = 0; j < NB; j++) begin
      if (j == NB - 1) begin
        b_dig[j] = {b_x[BXW-1], b_x[j*MUL_LIMB +: MUL_LIMB]};
      end else begin
        b_dig[j] = {1'b0, b_x[j*MUL_LIMB +: MUL_LIMB]};
      end
    end
  end

  // stage one: digit products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= a_dig[i] * b_dig[j];
        end
      end
    end
  end

  // stage two: one row per digit of a, modulo the product width
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_sum[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_sum[i] = row_sum[i] + (PW'(pp[i][j]) << (j * MUL_LIMB));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        row_q[i] <= row_sum[i];
      end
    end
  end

  // stage three: rows together
  always_comb begin
    total = '0;
    for (int i = 0; i < NA; i++) begin
      total = total + (row_q[i] << (i * MUL_LIMB));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= total;
    end
  end

endmodule

// ----- design/point_segment_classifier.sv -----
// point_segment_classifier: relation of a query point to a segment
// item channel: item_valid / item_stall, one beat per query carrying the
//   action bit (planar or spatial), segment start, segment end and query
//   point, each coordinate COORD_BITS wide, two's complement Q16.16
// result channel: result_valid / result_stall, one beat per item carrying
//   the relation code, in the order the items were taken
// configuration: APB-style port, tolerance at byte address 0, pready tied
//   high, write only while no item is in flight
// pipeline: an item beat taken passes through one stage of differences,
//   three stages of limb multipliers for the squares, dot and cross
//   terms, one stage of sums, three more multiplier stages for the wide
//   products, one stage of final sums and the output register
// throughput: one item per clock while item_stall is low, set by the fully
//   pipelined limb multipliers
// reset: synchronous, clears every valid bit and the skid stage and sets
//   the tolerance to 7; there is no memory and no clearing pass
// stall: a stalled result holds on the output register; one further beat
//   lands in the skid register, then item_stall rises and the whole
//   pipeline freezes until the output drains
module point_segment_classifier
  import psc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,

  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready,

  // item channel
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic                  action,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] start_z,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  input  logic [COORD_BITS-1:0] end_z,
  input  logic [COORD_BITS-1:0] query_x,
  input  logic [COORD_BITS-1:0] query_y,
  input  logic [COORD_BITS-1:0] query_z,

  // result channel
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [REL_W-1:0]      relation
);

  localparam int W    = COORD_BITS;
  localparam int DW   = W + 1;                 // coordinate difference
  localparam int SQW  = 2 * DW;                // difference product, also |n|^2
  localparam int DOTW = 2 * W + 3;             // dot product, signed
  localparam int BIGW = 2 * DOTW;              // |r|^2 |n|^2 and dot^2
  localparam int E2W  = 2 * TOL_BITS;          // tolerance squared
  localparam int E2NW = (E2W + 1) + DOTW;      // tolerance^2 |n|^2
  localparam int LOW  = (TOL_BITS + 1) + DOTW; // tolerance |n|^2
  localparam int OW   = ((BIGW > E2NW) ? BIGW : E2NW) + 1;
  localparam int PW   = DOTW + FRAC_BITS + 2;  // position sums

  // difference products
  localparam int M1_N    = 11;
  localparam int PR_NXNX = 0;
  localparam int PR_NYNY = 1;
  localparam int PR_NZNZ = 2;
  localparam int PR_RXRX = 3;
  localparam int PR_RYRY = 4;
  localparam int PR_RZRZ = 5;
  localparam int PR_RXNX = 6;
  localparam int PR_RYNY = 7;
  localparam int PR_RZNZ = 8;
  localparam int PR_RXNY = 9;
  localparam int PR_RYNX = 10;

  typedef struct packed {
    logic            action;
    logic            cneg;
    logic [SQW-1:0]  n2;
    logic [DOTW-1:0] dot;
  } side_t;

  // ---------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------
  logic [TOL_BITS-1:0] tolerance;
  logic [E2W-1:0]      tol_sq;
  logic                cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
    end else if (cfg_write && paddr[ADDR_W-1:2] == REG_TOLERANCE) begin
      tolerance <= pwdata[TOL_BITS-1:0];
    end
  end

  // settles long before an item reaches the second multiplier bank
  always_ff @(posedge clk) begin
    tol_sq <= tolerance * tolerance;
  end

  always_comb begin
    prdata = '0;
    if (paddr[ADDR_W-1:2] == REG_TOLERANCE) begin
      prdata = {{(DATA_W-TOL_BITS){1'b0}}, tolerance};
    end
  end

  // ---------------------------------------------------------------------
  // pipeline control: everything advances unless the skid stage is full
  // ---------------------------------------------------------------------
  logic en;
  logic skid_valid;

  assign en         = !skid_valid;
  assign item_stall = skid_valid;

  // ---------------------------------------------------------------------
  // stage 1: n = end - start, r = query - start; z dropped in planar mode
  // ---------------------------------------------------------------------
  logic          s1_valid;
  logic          s1_action;
  logic [DW-1:0] s1_nx, s1_ny, s1_nz, s1_rx, s1_ry, s1_rz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_action <= action;
      s1_nx     <= {end_x[W-1], end_x} - {start_x[W-1], start_x};
      s1_ny     <= {end_y[W-1], end_y} - {start_y[W-1], start_y};
      s1_rx     <= {query_x[W-1], query_x} - {start_x[W-1], start_x};
      s1_ry     <= {query_y[W-1], query_y} - {start_y[W-1], start_y};
      if (action == ACT_SPATIAL) begin
        s1_nz <= {end_z[W-1], end_z} - {start_z[W-1], start_z};
        s1_rz <= {query_z[W-1], query_z} - {start_z[W-1], start_z};
      end else begin
        s1_nz <= '0;
        s1_rz <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // stages 2-4: difference products
  // ---------------------------------------------------------------------
  logic [DW-1:0]         m1_a [M1_N];
  logic [DW-1:0]         m1_b [M1_N];
  logic [SQW-1:0]        m1_p [M1_N];
  logic [MUL_STAGES-1:0] m1_valid;
  logic [MUL_STAGES-1:0] m1_action;

  always_comb begin
    m1_a[PR_NXNX] = s1_nx;  m1_b[PR_NXNX] = s1_nx;
    m1_a[PR_NYNY] = s1_ny;  m1_b[PR_NYNY] = s1_ny;
    m1_a[PR_NZNZ] = s1_nz;  m1_b[PR_NZNZ] = s1_nz;
    m1_a[PR_RXRX] = s1_rx;  m1_b[PR_RXRX] = s1_rx;
    m1_a[PR_RYRY] = s1_ry;  m1_b[PR_RYRY] = s1_ry;
    m1_a[PR_RZRZ] = s1_rz;  m1_b[PR_RZRZ] = s1_rz;
    m1_a[PR_RXNX] = s1_rx;  m1_b[PR_RXNX] = s1_nx;
    m1_a[PR_RYNY] = s1_ry;  m1_b[PR_RYNY] = s1_ny;
    m1_a[PR_RZNZ] = s1_rz;  m1_b[PR_RZNZ] = s1_nz;
    m1_a[PR_RXNY] = s1_rx;  m1_b[PR_RXNY] = s1_ny;
    m1_a[PR_RYNX] = s1_ry;  m1_b[PR_RYNX] = s1_nx;
  end

  for (genvar g = 0; g < M1_N; g++) begin : g_m1
    psc_mul #(
      .AW (DW),
      .BW (DW)
    ) u_mul (
      .clk (clk),
      .en  (en),
      .a   (m1_a[g]),
      .b   (m1_b[g]),
      .p   (m1_p[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= '0;
    end else if (en) begin
      m1_valid <= {m1_valid[MUL_STAGES-2:0], s1_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_action <= {m1_action[MUL_STAGES-2:0], s1_action};
    end
  end

  // ---------------------------------------------------------------------
  // stage 5: |n|^2, |r|^2, r.n and the sign of the planar cross product
  // ---------------------------------------------------------------------
  logic           s5_valid;
  side_t          s5_side;
  logic [SQW-1:0] s5_r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (en) begin
      s5_valid <= m1_valid[MUL_STAGES-1];
    end
  end

  // squares are never negative, so they add as plain unsigned values
  always_ff @(posedge clk) begin
    if (en) begin
      s5_side.action <= m1_action[MUL_STAGES-1];
      s5_side.cneg   <= $signed(m1_p[PR_RXNY]) < $signed(m1_p[PR_RYNX]);
      s5_side.n2     <= m1_p[PR_NXNX] + m1_p[PR_NYNY] + m1_p[PR_NZNZ];
      s5_side.dot    <= {m1_p[PR_RXNX][SQW-1], m1_p[PR_RXNX]}
                      + {m1_p[PR_RYNY][SQW-1], m1_p[PR_RYNY]}
                      + {m1_p[PR_RZNZ][SQW-1], m1_p[PR_RZNZ]};
      s5_r2          <= m1_p[PR_RXRX] + m1_p[PR_RYRY] + m1_p[PR_RZRZ];
    end
  end

  // ---------------------------------------------------------------------
  // stages 6-8: wide products
  // |r x n|^2 = |r|^2 |n|^2 - (r.n)^2 holds in both modes
  // ---------------------------------------------------------------------
  logic [BIGW-1:0]       r2n2;
  logic [BIGW-1:0]       dot2;
  logic [E2NW-1:0]       e2n2;
  logic [LOW-1:0]        lo_n2;
  logic [MUL_STAGES-1:0] m2_valid;
  side_t                 m2_side [MUL_STAGES];
  side_t                 m2_last;

  psc_mul #(
    .AW (DOTW),
    .BW (DOTW)
  ) u_mul_r2n2 (
    .clk (clk),
    .en  (en),
    .a   ({1'b0, s5_r2}),
    .b   ({1'b0, s5_side.n2}),
    .p   (r2n2)
  );

  psc_mul #(
    .AW (DOTW),
    .BW (DOTW)
  ) u_mul_dot2 (
    .clk (clk),
    .en  (en),
    .a   (s5_side.dot),
    .b   (s5_side.dot),
    .p   (dot2)
  );

  psc_mul #(
    .AW (E2W + 1),
    .BW (DOTW)
  ) u_mul_e2n2 (
    .clk (clk),
    .en  (en),
    .a   ({1'b0, tol_sq}),
    .b   ({1'b0, s5_side.n2}),
    .p   (e2n2)
  );

  psc_mul #(
    .AW (TOL_BITS + 1),
    .BW (DOTW)
  ) u_mul_lo (
    .clk (clk),
    .en  (en),
    .a   ({1'b0, tolerance}),
    .b   ({1'b0, s5_side.n2}),
    .p   (lo_n2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= '0;
    end else if (en) begin
      m2_valid <= {m2_valid[MUL_STAGES-2:0], s5_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_side[0] <= s5_side;
      for (int k = 1; k < MUL_STAGES; k++) begin
        m2_side[k] <= m2_side[k-1];
      end
    end
  end

  assign m2_last = m2_side[MUL_STAGES-1];

  // ---------------------------------------------------------------------
  // stage 9: offset margin and the four position sums
  // with P = dot << 16, Q = (dot - |n|^2) << 16 and lo = tolerance |n|^2:
  //   pa = P + lo   below zero: before
  //   pb = P - lo   above zero: past the start band
  //   pc = Q - lo   above zero: after
  //   pd = Q + lo   below zero: short of the end band
  // ---------------------------------------------------------------------
  logic            s9_valid;
  logic            s9_action;
  logic            s9_cneg;
  logic            s9_nzero;
  logic [OW-1:0]   s9_off;
  logic [PW-1:0]   s9_pa, s9_pb, s9_pc, s9_pd;

  logic [PW-1:0]   dot_p;
  logic [PW-1:0]   n2_p;
  logic [PW-1:0]   lo_p;

  assign dot_p = {{(PW-DOTW){m2_last.dot[DOTW-1]}}, m2_last.dot} << FRAC_BITS;
  assign n2_p  = {{(PW-SQW){1'b0}}, m2_last.n2} << FRAC_BITS;
  assign lo_p  = {{(PW-LOW){1'b0}}, lo_n2};

  always_ff @(posedge clk) begin
    if (rst) begin
      s9_valid <= 1'b0;
    end else if (en) begin
      s9_valid <= m2_valid[MUL_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s9_action <= m2_last.action;
      s9_cneg   <= m2_last.cneg;
      s9_nzero  <= (m2_last.n2 == '0);
      s9_off    <= {{(OW-BIGW){1'b0}}, r2n2}
                 - {{(OW-BIGW){1'b0}}, dot2}
                 - {{(OW-E2NW){1'b0}}, e2n2};
      s9_pa     <= dot_p + lo_p;
      s9_pb     <= dot_p - lo_p;
      s9_pc     <= dot_p - n2_p - lo_p;
      s9_pd     <= dot_p - n2_p + lo_p;
    end
  end

  // ---------------------------------------------------------------------
  // relation decode, in priority order
  // ---------------------------------------------------------------------
  rel_t rel_next;
  logic off_far;

  // squared distance beyond the tolerance band
  assign off_far = !s9_off[OW-1] && (s9_off != '0);

  always_comb begin
    if (s9_nzero) begin
      rel_next = REL_UNKNOWN;
    end else if (off_far) begin
      if (s9_action == ACT_SPATIAL) begin
        rel_next = REL_DISJOINT;
      end else if (s9_cneg) begin
        rel_next = REL_LEFT;
      end else begin
        rel_next = REL_RIGHT;
      end
    end else if (s9_pa[PW-1]) begin
      rel_next = REL_BEFORE;
    end else if (!s9_pc[PW-1] && s9_pc != '0) begin
      rel_next = REL_AFTER;
    end else if (!s9_pb[PW-1] && s9_pb != '0 && s9_pd[PW-1]) begin
      rel_next = REL_BETWEEN;
    end else if (s9_pb[PW-1]) begin
      rel_next = REL_AT_START;
    end else if (!s9_pd[PW-1] && s9_pd != '0) begin
      rel_next = REL_AT_END;
    end else begin
      // exactly on a band edge
      rel_next = REL_UNKNOWN;
    end
  end

  // ---------------------------------------------------------------------
  // output register and skid stage
  // ---------------------------------------------------------------------
  logic out_valid;
  rel_t out_rel;
  rel_t skid_rel;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // pipeline frozen, drain the skid beat first
      if (!result_stall) begin
        out_rel    <= skid_rel;
        skid_valid <= 1'b0;
      end
    end else if (s9_valid) begin
      if (!out_valid || !result_stall) begin
        out_valid <= 1'b1;
        out_rel   <= rel_next;
      end else begin
        skid_valid <= 1'b1;
        skid_rel   <= rel_next;
      end
    end else if (!result_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign result_valid = out_valid;
  assign relation     = out_rel;

`ifndef ASSERT_OFF
  // the skid stage only fills behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage full with no output beat");

  // a full skid stage freezes the last pipeline stage
  a_pipe_frozen: assert property (@(posedge clk) disable iff (rst)
    skid_valid |=> $stable(s9_valid) && $stable(s9_pa) && $stable(s9_off))
    else $error("pipeline moved while skid stage full");

  // a finished beat meeting a stalled output goes to the skid stage
  a_skid_catch: assert property (@(posedge clk) disable iff (rst)
    !skid_valid && s9_valid && out_valid && result_stall |=> skid_valid)
    else $error("finished beat dropped under stall");

  // |r|^2 |n|^2 never falls below (r.n)^2, so the squared cross product
  // is never negative
  a_cross_nonneg: assert property (@(posedge clk) disable iff (rst)
    m2_valid[MUL_STAGES-1] |-> $signed({1'b0, r2n2}) >= $signed({1'b0, dot2}))
    else $error("wide products disagree");
`endif

endmodule

// ----- dv/tb_point_segment_classifier.sv -----
`timescale 1ns / 1ps

module tb_point_segment_classifier;
  import psc_pkg::*;

  // coordinate width and the wide signed type the relation predictor works in;
  // the largest term, the squared cross product summed over three axes,
  // needs 133 bits
  localparam int CW          = COORD_BITS_DEF;
  localparam int ONE         = 1 << FRAC_BITS;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 40;

  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};

  // byte addresses: the tolerance register and the unused slot above it
  localparam logic [ADDR_W-1:0] ADDR_TOL   = {REG_TOLERANCE, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_SPARE = {REG_IDX_W'(1), 2'b00};

  typedef logic signed [191:0] wide_t;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } vec_t;

  // one query beat: mode, segment start, segment end, query point
  typedef struct {
    logic act;
    vec_t s;
    vec_t e;
    vec_t q;
  } query_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  logic          item_valid = 1'b0;
  logic          item_stall;
  logic          action     = ACT_PLANAR;
  logic [CW-1:0] start_x = '0, start_y = '0, start_z = '0;
  logic [CW-1:0] end_x   = '0, end_y   = '0, end_z   = '0;
  logic [CW-1:0] query_x = '0, query_y = '0, query_z = '0;

  logic             result_valid;
  logic             result_stall = 1'b0;
  logic [REL_W-1:0] relation;

  // expected relation codes, oldest first, and the tolerance the block holds
  rel_t                pending_rel[$];
  logic [TOL_BITS-1:0] tol_shadow = TOL_RESET;

  int n_errors      = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // long result hold-off, counted in its own process
  event hold_go;
  logic holding = 1'b0;

  point_segment_classifier u_top (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .action       (action),
    .start_x      (start_x),
    .start_y      (start_y),
    .start_z      (start_z),
    .end_x        (end_x),
    .end_y        (end_y),
    .end_z        (end_z),
    .query_x      (query_x),
    .query_y      (query_y),
    .query_z      (query_z),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .relation     (relation)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // relation predictor
  // ---------------------------------------------------------------------------

  function automatic wide_t coord_sub(logic signed [CW-1:0] a, logic signed [CW-1:0] b);
    wide_t wa, wb;
    wa = a;
    wb = b;
    return wa - wb;
  endfunction

  // exact classification: every test squared and cross-multiplied, so no
  // division or root is needed and ties land exactly
  function automatic rel_t classify_relation(query_t it, logic [TOL_BITS-1:0] tol);
    wide_t nx, ny, nz, rx, ry, rz, eps, unit, n2, lim;
    wide_t c, cx, cy, cz, off, dot, p, lo, hi_plus, hi_minus;
    nx   = coord_sub(it.e.x, it.s.x);
    ny   = coord_sub(it.e.y, it.s.y);
    rx   = coord_sub(it.q.x, it.s.x);
    ry   = coord_sub(it.q.y, it.s.y);
    nz   = '0;
    rz   = '0;
    eps  = tol;
    unit = ONE;
    if (it.act == ACT_SPATIAL) begin
      nz = coord_sub(it.e.z, it.s.z);
      rz = coord_sub(it.q.z, it.s.z);
    end
    n2 = nx * nx + ny * ny + nz * nz;
    // degenerate segment has no direction
    if (n2 == 0) return REL_UNKNOWN;
    lim = eps * eps * n2;

    // offset from the line, compared as squared distance times |n|^2
    if (it.act == ACT_SPATIAL) begin
      cx  = ry * nz - rz * ny;
      cy  = rz * nx - rx * nz;
      cz  = rx * ny - ry * nx;
      off = cx * cx + cy * cy + cz * cz;
      if (off > lim) return REL_DISJOINT;
    end else begin
      c = rx * ny - ry * nx;
      if (c * c > lim) return (c < 0) ? REL_LEFT : REL_RIGHT;
    end

    // projection parameter t = dot / |n|^2, scaled by one in Q16.16
    dot      = rx * nx + ry * ny + rz * nz;
    p        = dot * unit;
    lo       = eps * n2;
    hi_plus  = (unit + eps) * n2;
    hi_minus = (unit - eps) * n2;
    if (p < -lo) return REL_BEFORE;
    if (p > hi_plus) return REL_AFTER;
    if (p > lo && p < hi_minus) return REL_BETWEEN;
    if (p < lo) return REL_AT_START;
    if (p > hi_minus) return REL_AT_END;
    // t sits exactly on e or 1-e
    return REL_UNKNOWN;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic vec_t vec(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                               logic signed [CW-1:0] z);
    vec_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    return v;
  endfunction

  function automatic query_t mk_query(logic act, vec_t s, vec_t e, vec_t q);
    query_t it;
    it.act = act;
    it.s   = s;
    it.e   = e;
    it.q   = q;
    return it;
  endfunction

  // signed value within +/- 2^bits
  function automatic logic signed [CW-1:0] rnd_coord(int bits);
    return $signed($urandom()) >>> (31 - bits);
  endfunction

  // offset of about the tolerance either way, or none a third of the time
  function automatic longint jitter(longint j);
    if ($urandom_range(2) == 0) return 0;
    return longint'($urandom_range(0, 2 * j)) - j;
  endfunction

  function automatic query_t random_query(logic [TOL_BITS-1:0] tol);
    query_t it;
    longint nx, ny, nz, off, jit;
    int     kind, sh, k, m;
    kind   = $urandom_range(99);
    it.act = $urandom_range(1);

    // raw noise: every bit of every coordinate toggles
    if (kind < 15) begin
      it.s = vec($urandom(), $urandom(), $urandom());
      it.e = vec($urandom(), $urandom(), $urandom());
      it.q = vec($urandom(), $urandom(), $urandom());
      return it;
    end

    // axis-aligned segment of whole units, point on a boundary of t or one lsb off
    if (kind < 30) begin
      m      = $urandom_range(1, 64);
      it.s   = vec(rnd_coord(28), rnd_coord(28), rnd_coord(28));
      it.e   = it.s;
      it.e.x = it.s.x + m * ONE;
      case ($urandom_range(5))
        0:       off = -longint'(tol);
        1:       off = tol;
        2:       off = ONE - tol;
        3:       off = ONE + tol;
        4:       off = 0;
        default: off = ONE;
      endcase
      off = m * off;
      if ($urandom_range(1)) off = off + ($urandom_range(1) ? 1 : -1);
      it.q   = it.s;
      it.q.x = it.s.x + off;
      // z plays no part in planar mode
      if (it.act == ACT_PLANAR) begin
        it.e.z = $urandom();
        it.q.z = $urandom();
      end
      return it;
    end

    // point near the line with t spread over -0.5 .. 1.5, mostly short segments
    sh   = ($urandom_range(7) == 0) ? $urandom_range(20, 30) : $urandom_range(0, 19);
    it.s = vec(rnd_coord(30), rnd_coord(30), rnd_coord(30));
    nx   = rnd_coord(sh);
    ny   = rnd_coord(sh);
    nz   = rnd_coord(sh);
    k    = $urandom_range(16);
    jit  = longint'(tol) + 2;
    it.e = vec(it.s.x + nx, it.s.y + ny, it.s.z + nz);
    it.q = vec(it.s.x + nx * (k - 4) / 8 + jitter(jit),
               it.s.y + ny * (k - 4) / 8 + jitter(jit),
               it.s.z + nz * (k - 4) / 8 + jitter(jit));
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------

  task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // register takes the value at this edge; unused slots drop it
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_TOL) tol_shadow = data[TOL_BITS-1:0];
    // leave the bus idle before the next transfer
    @(posedge clk);
  endtask

  task automatic check_tol_readback();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_TOL;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // access phase: prdata is sampled as it stood before this edge
    if (prdata !== DATA_W'(tol_shadow)) begin
      if (n_errors < MAX_REPORTS)
        $display("%0t: tolerance readback expected %0d got %0d", $time, tol_shadow, prdata);
      n_errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // upper data bits random: the block keeps only the low TOL_BITS
  task automatic set_tolerance(logic [TOL_BITS-1:0] tol);
    apb_write(ADDR_TOL, ($urandom() & ~32'h7fff) | DATA_W'(tol));
  endtask

  // ---------------------------------------------------------------------------
  // item channel
  // ---------------------------------------------------------------------------

  // drive one beat, hold it until taken, record its expected relation, then
  // maybe leave a gap
  task automatic send_item(query_t it);
    item_valid <= 1'b1;
    action     <= it.act;
    start_x    <= it.s.x;
    start_y    <= it.s.y;
    start_z    <= it.s.z;
    end_x      <= it.e.x;
    end_y      <= it.e.y;
    end_z      <= it.e.z;
    query_x    <= it.q.x;
    query_y    <= it.q.y;
    query_z    <= it.q.z;
    do @(posedge clk); while (item_stall !== 1'b0);
    pending_rel.push_back(classify_relation(it, tol_shadow));
    if ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // stop offering beats and let every expected relation come back
  task automatic drain();
    item_valid <= 1'b0;
    while (pending_rel.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stall plus the long hold-off
  // ---------------------------------------------------------------------------

  always @(posedge clk)
    result_stall <= holding || ($urandom_range(99) < recv_idle_pct);

  initial forever begin
    @(hold_go);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding <= 1'b0;
  end

  // every taken result beat against the oldest expectation
  always @(posedge clk) begin
    rel_t exp_rel;
    if (!rst && result_valid === 1'b1 && result_stall === 1'b0) begin
      if (pending_rel.size() == 0) begin
        if (n_errors < MAX_REPORTS)
          $display("%0t: unexpected result, expected none got relation %0d", $time, relation);
        n_errors++;
      end else begin
        exp_rel = pending_rel.pop_front();
        if (relation !== exp_rel) begin
          if (n_errors < MAX_REPORTS)
            $display("%0t: relation expected %0d got %0d", $time, exp_rel, relation);
          n_errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset value, bits above the field dropped, unused slot leaves tolerance alone
  task automatic test_register_access();
    check_tol_readback();
    apb_write(ADDR_TOL, 32'hffff_ffff);
    check_tol_readback();
    apb_write(ADDR_SPARE, 32'h0000_0000);
    check_tol_readback();
    apb_write(ADDR_TOL, DATA_W'(TOL_RESET));
    check_tol_readback();
  endtask

  task automatic test_directed_cases();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    // zero-length segments: all equal, planar with only z apart, spatial
    send_item(mk_query(ACT_PLANAR,  vec(0, 0, 0), vec(0, 0, 0), vec(5, 5, 0)));
    send_item(mk_query(ACT_PLANAR,  vec(ONE, ONE, 0), vec(ONE, ONE, 9 * ONE), vec(0, 0, 0)));
    send_item(mk_query(ACT_SPATIAL, vec(ONE, -ONE, ONE), vec(ONE, -ONE, ONE), vec(3, 4, 5)));
    // planar sides
    send_item(mk_query(ACT_PLANAR, vec(0, 0, 0), vec(ONE, 0, 0), vec(ONE / 2, ONE, 0)));
    send_item(mk_query(ACT_PLANAR, vec(0, 0, 0), vec(ONE, 0, 0), vec(ONE / 2, -ONE, 0)));
    // spatial off the line
    send_item(mk_query(ACT_SPATIAL, vec(0, 0, 0), vec(ONE, 0, 0), vec(ONE / 2, 0, ONE)));
    // positions along a unit segment, tolerance 7 lsb
    send_item(mk_query(ACT_SPATIAL, vec(0, 0, 0), vec(ONE, 0, 0), vec(-ONE, 0, 0)));
    send_item(mk_query(ACT_SPATIAL, vec(0, 0, 0), vec(ONE, 0, 0), vec(2 * ONE, 0, 0)));
    send_item(mk_query(ACT_SPATIAL, vec(0, 0, 0), vec(ONE, 0, 0), vec(ONE / 2, 0, 0)));
    send_item(mk_query(ACT_SPATIAL, vec(0, 0, 0), vec(ONE, 0, 0), vec(3, 0, 0)));
    send_item(mk_query(ACT_PLANAR,  vec(0, 0, 0), vec(ONE, 0, 0), vec(ONE - 3, 0, 0)));
    // exact ties at t = e and t = 1 - e fall through to unknown
    send_item(mk_query(ACT_SPATIAL, vec(0, 0, 0), vec(ONE, 0, 0), vec(7, 0, 0)));
    send_item(mk_query(ACT_PLANAR,  vec(0, 0, 0), vec(ONE, 0, 0), vec(ONE - 7, 0, 0)));
    // t = -e and t = 1 + e sit inside the end windows
    send_item(mk_query(ACT_SPATIAL, vec(0, 0, 0), vec(ONE, 0, 0), vec(-7, 0, 0)));
    send_item(mk_query(ACT_SPATIAL, vec(0, 0, 0), vec(ONE, 0, 0), vec(ONE + 7, 0, 0)));
    // coordinate extremes
    send_item(mk_query(ACT_PLANAR,  vec(CMIN, CMIN, CMIN), vec(CMAX, CMAX, CMAX),
                       vec(CMAX, CMIN, CMAX)));
    send_item(mk_query(ACT_SPATIAL, vec(CMIN, CMIN, CMIN), vec(CMAX, CMAX, CMAX),
                       vec(CMIN, CMAX, CMIN)));
    send_item(mk_query(ACT_SPATIAL, vec(CMAX, CMAX, CMAX), vec(CMIN, CMIN, CMIN),
                       vec(CMAX, CMAX, CMAX)));
    send_item(mk_query(ACT_PLANAR,  vec(CMAX, CMIN, 0), vec(CMIN, CMAX, 0),
                       vec(CMIN, CMAX, CMAX)));
    drain();
    // zero tolerance: the end points themselves become ties
    set_tolerance('0);
    send_item(mk_query(ACT_SPATIAL, vec(ONE, ONE, ONE), vec(3 * ONE, ONE, ONE),
                       vec(ONE, ONE, ONE)));
    send_item(mk_query(ACT_PLANAR,  vec(ONE, ONE, 0), vec(3 * ONE, ONE, 0),
                       vec(3 * ONE, ONE, 0)));
    send_item(mk_query(ACT_PLANAR,  vec(ONE, ONE, 0), vec(3 * ONE, ONE, 0),
                       vec(2 * ONE, ONE, 0)));
    send_item(mk_query(ACT_PLANAR,  vec(ONE, ONE, 0), vec(3 * ONE, ONE, 0),
                       vec(2 * ONE, ONE + 1, 0)));
    drain();
  endtask

  // random beats at a given idle mix, over zero, largest, random and reset tolerance
  task automatic test_random_phase(int send_pct, int recv_pct, int n_items);
    logic [TOL_BITS-1:0] tol;
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
    for (int leg = 0; leg < 4; leg++) begin
      case (leg)
        0:       tol = '0;
        1:       tol = '1;
        2:       tol = $urandom_range(1, (1 << TOL_BITS) - 2);
        default: tol = TOL_RESET;
      endcase
      drain();
      set_tolerance(tol);
      for (int i = 0; i < n_items / 4; i++) send_item(random_query(tol_shadow));
    end
    drain();
  endtask

  // results held back long enough that the pipeline fills and stalls its input
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    -> hold_go;
    for (int i = 0; i < 48; i++) send_item(random_query(tol_shadow));
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_access();
    test_directed_cases();
    test_random_phase(13, 52, 500);
    test_backpressure();
    test_random_phase(52, 13, 500);
    test_random_phase(0, 0, 500);
    // anything late or extra shows up in the checker during this wait
    repeat (20) @(posedge clk);
    if (n_errors == 0 && pending_rel.size() == 0)
      $display("point_segment_classifier test passed");
    else
      $display("point_segment_classifier test failed");
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("point_segment_classifier test failed");
    $finish;
  end

endmodule
